@@ design/pfalu_pkg.sv @@
// ----------------------------------------------------------------------------
// pfalu_pkg: shared definitions for the prime field ALU
// Operation and status codes, default data width and the control bundles
// passed between the sequencer, the modular adder and the top level.
// ----------------------------------------------------------------------------
package pfalu_pkg;

   localparam int WIDTH_DEFAULT = 32;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_POW = 3'd3;
   localparam logic [2:0] OP_DIV = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   typedef struct packed {
      logic sub;
      logic cin;
   } pfalu_uctl_type;

   typedef struct packed {
      logic       done;
      logic [1:0] status;
   } pfalu_done_type;

endpackage

@@ design/pfalu_addsub.sv @@
// ----------------------------------------------------------------------------
// pfalu_addsub: shared modular add / subtract unit
// Add: (x + y + cin) reduced once against m. Subtract: x - y, wrapped by m
// when it borrows. Operands are expected in range for a single correction.
// ----------------------------------------------------------------------------
module pfalu_addsub import pfalu_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic [WIDTH-1:0] unit_x,
   input  logic [WIDTH-1:0] unit_y,
   input  logic [WIDTH-1:0] unit_m,
   input  pfalu_uctl_type   unit_ctl,
   output logic [WIDTH-1:0] unit_r
);

   logic [WIDTH:0] sum;
   logic [WIDTH:0] red;
   logic [WIDTH:0] diff;
   logic [WIDTH:0] wrap;

   always_comb begin
      sum  = {1'b0, unit_x} + {1'b0, unit_y} + {{WIDTH{1'b0}}, unit_ctl.cin};
      red  = sum - {1'b0, unit_m};
      diff = {1'b0, unit_x} - {1'b0, unit_y};
      wrap = diff + {1'b0, unit_m};
      if (unit_ctl.sub) begin
         unit_r = diff[WIDTH] ? wrap[WIDTH-1:0] : diff[WIDTH-1:0];
      end else begin
         unit_r = (sum >= {1'b0, unit_m}) ? red[WIDTH-1:0] : sum[WIDTH-1:0];
      end
   end

endmodule

@@ design/pfalu_core.sv @@
// ----------------------------------------------------------------------------
// pfalu_core: sequencer and operand registers of the prime field ALU
// Runs add, sub, shift-add-reduce multiply, square-and-multiply power,
// exponent reduction and inversion through one shared modular adder.
// ----------------------------------------------------------------------------
module pfalu_core import pfalu_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              op,
   input  logic [WIDTH-1:0]        opnd_a,
   input  logic [WIDTH-1:0]        opnd_b,
   input  logic signed [WIDTH-1:0] expo,
   input  logic [WIDTH-1:0]        modulus,
   input  logic                    out_free,
   output logic                    idle,
   output pfalu_done_type          done_info,
   output logic [WIDTH-1:0]        value
);

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_ADDSUB = 9'b000000010,
      S_MDBL   = 9'b000000100,
      S_MADD   = 9'b000001000,
      S_MRET   = 9'b000010000,
      S_REM    = 9'b000100000,
      S_RFIX   = 9'b001000000,
      S_PSQ    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PH_FINAL = 2'd0,
      PH_SQ    = 2'd1,
      PH_PM    = 2'd2
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [2:0]       op_ff, op_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] mx_ff, mx_in;
   logic [WIDTH-1:0] my_ff, my_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    ecnt_ff, ecnt_in;
   logic [WIDTH-1:0] val_ff, val_in;
   logic [1:0]       st_ff, st_in;

   logic [WIDTH-1:0] ux, uy, um, ur;
   pfalu_uctl_type   uctl;
   logic [WIDTH-1:0] order;
   logic [WIDTH-1:0] mag;
   logic             uses_b;
   logic             range_bad;

   pfalu_addsub #(.WIDTH(WIDTH)) u_addsub (
      .unit_x   (ux),
      .unit_y   (uy),
      .unit_m   (um),
      .unit_ctl (uctl),
      .unit_r   (ur)
   );

   assign order     = modulus - WIDTH'(1);
   assign mag       = ~expo + WIDTH'(1);
   assign uses_b    = op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
   assign range_bad = (modulus < WIDTH'(2)) || (opnd_a >= modulus) ||
                      (uses_b && (opnd_b >= modulus));

   assign idle             = (state_ff == S_IDLE);
   assign done_info.done   = (state_ff == S_DONE);
   assign done_info.status = st_ff;
   assign value            = val_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      base_in  = base_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      ecnt_in  = ecnt_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      ux       = acc_ff;
      uy       = acc_ff;
      um       = modulus;
      uctl.sub = 1'b0;
      uctl.cin = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op;
               a_in     = opnd_a;
               mx_in    = opnd_a;
               my_in    = opnd_b;
               acc_in   = '0;
               cnt_in   = '0;
               ecnt_in  = '0;
               res_in   = WIDTH'(1);
               phase_in = PH_FINAL;
               val_in   = '0;
               st_in    = ST_OK;
               base_in  = (op == OP_DIV) ? opnd_b : opnd_a;
               exp_in   = (op == OP_DIV) ? (modulus - WIDTH'(2)) : expo;
               if (!(op inside {OP_ADD, OP_SUB, OP_MUL, OP_POW, OP_DIV})) begin
                  state_in = S_DONE;
               end else if (range_bad) begin
                  st_in    = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  case (op)
                     OP_ADD, OP_SUB: state_in = S_ADDSUB;
                     OP_MUL: state_in = S_MDBL;
                     OP_POW: begin
                        if (expo[WIDTH-1]) begin
                           my_in    = mag;
                           state_in = S_REM;
                        end else begin
                           state_in = S_PSQ;
                        end
                     end
                     default: begin
                        if (opnd_b == '0) begin
                           st_in    = ST_DIVZERO;
                           state_in = S_DONE;
                        end else begin
                           state_in = S_PSQ;
                        end
                     end
                  endcase
               end
            end
         end
         S_ADDSUB: begin
            ux       = mx_ff;
            uy       = my_ff;
            uctl.sub = (op_ff == OP_SUB);
            val_in   = ur;
            state_in = S_DONE;
         end
         S_MDBL, S_MADD: begin
            if (state_ff == S_MADD) begin
               uy = mx_ff;
            end
            acc_in = ur;
            if ((state_ff == S_MDBL) && my_ff[WIDTH-1]) begin
               state_in = S_MADD;
            end else begin
               my_in  = my_ff << 1;
               cnt_in = cnt_ff + CW'(1);
               state_in = (cnt_ff == CNT_LAST) ? S_MRET : S_MDBL;
            end
         end
         S_MRET: begin
            if (phase_ff == PH_FINAL) begin
               val_in   = acc_ff;
               state_in = S_DONE;
            end else if ((phase_ff == PH_SQ) && exp_ff[WIDTH-1]) begin
               res_in   = acc_ff;
               mx_in    = base_ff;
               my_in    = acc_ff;
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_PM;
               state_in = S_MDBL;
            end else begin
               res_in  = acc_ff;
               exp_in  = exp_ff << 1;
               ecnt_in = ecnt_ff + CW'(1);
               if (ecnt_ff != CNT_LAST) begin
                  state_in = S_PSQ;
               end else if (op_ff == OP_DIV) begin
                  mx_in    = a_ff;
                  my_in    = acc_ff;
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_FINAL;
                  state_in = S_MDBL;
               end else begin
                  val_in   = acc_ff;
                  state_in = S_DONE;
               end
            end
         end
         S_REM: begin
            um       = order;
            uctl.cin = my_ff[WIDTH-1];
            acc_in   = ur;
            my_in    = my_ff << 1;
            cnt_in   = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_RFIX;
            end
         end
         S_RFIX: begin
            ux       = order;
            uy       = acc_ff;
            uctl.sub = 1'b1;
            exp_in   = (acc_ff == '0) ? '0 : ur;
            state_in = S_PSQ;
         end
         S_PSQ: begin
            mx_in    = res_ff;
            my_in    = res_ff;
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = PH_SQ;
            state_in = S_MDBL;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      cnt_ff   <= cnt_in;
      ecnt_ff  <= ecnt_in;
      val_ff   <= val_in;
      st_ff    <= st_in;
   end

endmodule

@@ design/prime_field_alu.sv @@
// ----------------------------------------------------------------------------
// prime_field_alu: arithmetic unit over GF(p)
// Add, sub, mul, pow and div of field elements with p held in a register.
//
//   channel  dir  transfer               payload
//   req      in   req_valid & req_ready  req_op, req_operand_a/b, req_exponent
//   rsp      out  rsp_valid & rsp_ready  rsp_value, rsp_status
//   csr      in   csr_valid & csr_ready  csr_modulus
//
// One item at a time through one shared modular adder. Pow runs WIDTH squarings
// and one multiply per set bit of n, with a negative exponent first reduced mod
// p - 1; div is one inversion pow plus one mul. Synchronous reset sets p to 2;
// the result register lets the next request start while a result waits on
// rsp_ready.
// ----------------------------------------------------------------------------
module prime_field_alu import pfalu_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_op,
   input  logic [WIDTH-1:0]        req_operand_a,
   input  logic [WIDTH-1:0]        req_operand_b,
   input  logic signed [WIDTH-1:0] req_exponent,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [WIDTH-1:0]        rsp_value,
   output logic [1:0]              rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [WIDTH-1:0]        csr_modulus
);

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic             core_idle;
   logic             out_free;
   pfalu_done_type   core_done;
   logic [WIDTH-1:0] core_value;

   pfalu_core #(.WIDTH(WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid & req_ready),
      .op        (req_op),
      .opnd_a    (req_operand_a),
      .opnd_b    (req_operand_b),
      .expo      (req_exponent),
      .modulus   (modulus_ff),
      .out_free  (out_free),
      .idle      (core_idle),
      .done_info (core_done),
      .value     (core_value)
   );

   assign req_ready  = core_idle;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      modulus_in    = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (core_done.done && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = core_value;
         rsp_status_in = core_done.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
